// ----- hw/rtl/bfa_pkg.sv -----
// Package for the best-fit arena allocator.
// Holds the sequencer state type, the status and action codes and the config word.
// No dependencies.
package bfa_pkg;

    localparam int UNITS_W = 13;
    localparam int NEED_W  = 13;

    localparam logic       ACT_ALLOC = 1'b0;
    localparam logic       ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_OFF   = 2'd2;

    localparam logic [1:0] REG_ARENA_UNITS = 2'd0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_START,
        S_A_WALK,
        S_A_DECIDE,
        S_A_TAIL,
        S_F_HDR,
        S_F_WALK,
        S_F_PQ,
        S_F_Q,
        S_F_P,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               wr;
        logic [UNITS_W-1:0] units;
    } t_cfg;

endpackage

// ----- hw/rtl/bfa_if.sv -----
// Valid/ready channel interfaces for the allocator request and result words.
// No dependencies.
interface bfa_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] req_bytes;
    logic [15:0] free_offset;

    modport source(output valid, action, req_bytes, free_offset, input ready);
    modport sink(input valid, action, req_bytes, free_offset, output ready);
endinterface

interface bfa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] payload_offset;

    modport source(output valid, status, payload_offset, input ready);
    modport sink(input valid, status, payload_offset, output ready);
endinterface

// ----- hw/rtl/bfa_hdr_mem.sv -----
// Header store of the allocator: next pointer and size per arena unit.
// Two synchronous memories, one shared read address with registered read data, separate write ports.
module bfa_hdr_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int SW    = 13
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output logic [AW-1:0] o_rd_next,
    output logic [SW-1:0] o_rd_size,
    input  logic          i_wn_en,
    input  logic [AW-1:0] i_wn_addr,
    input  logic [AW-1:0] i_wn_data,
    input  logic          i_ws_en,
    input  logic [AW-1:0] i_ws_addr,
    input  logic [SW-1:0] i_ws_data
);

    logic [AW-1:0] next_mem [DEPTH];
    logic [SW-1:0] size_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wn_en) begin
            next_mem[i_wn_addr] <= i_wn_data;
        end
        o_rd_next <= next_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ws_en) begin
            size_mem[i_ws_addr] <= i_ws_data;
        end
        o_rd_size <= size_mem[i_rd_addr];
    end

endmodule

// ----- hw/rtl/bfa_apb_cfg.sv -----
// APB register slave for the arena size register.
// Depends on bfa_pkg.
module bfa_apb_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bfa_pkg::t_cfg o_cfg
);
    import bfa_pkg::*;

    logic [UNITS_W-1:0] r_units;
    logic               w_wr;

    assign w_wr   = psel && penable && pwrite && (paddr == REG_ARENA_UNITS);
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ARENA_UNITS) ? 32'(r_units) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_units <= UNITS_W'(4096);
        end else if (w_wr) begin
            r_units <= pwdata[UNITS_W-1:0];
        end
    end

    assign o_cfg.wr    = w_wr;
    assign o_cfg.units = r_units;

endmodule

// ----- hw/rtl/best_fit_arena_allocator_core.sv -----
// Best-fit arena allocator: address-ordered circular free list with coalescing.
// Allocate walks the free list from the rover for the best fit, one free block per cycle, and may split
// the tail off a larger block. Free walks list headers from the rover, one per cycle, and a free that
// absorbs the lone free block ends early; bad frees and frees onto an empty list end without a walk.
// One item at a time, paced by the single read port of the header memory.
// After reset and after each arena size write, a clearing pass over all ARENA_UNITS header entries runs
// with the request channel held off. Result is held in an output register.
module best_fit_arena_allocator_core #(
    parameter int ARENA_UNITS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    bfa_in_if.sink      i_in,
    bfa_out_if.source   o_out
);
    import bfa_pkg::*;

    localparam int IW = $clog2(ARENA_UNITS);
    localparam int SW = $clog2(ARENA_UNITS + 1);
    localparam int CW = (SW > UNITS_W) ? SW : UNITS_W;

    t_cfg w_cfg;
    t_state r_state, n_state;

    logic [SW-1:0] w_n;
    logic [IW-1:0] w_rd_addr, r_rd_addr;
    logic [IW-1:0] w_mnext, w_gnext;
    logic [SW-1:0] w_msize, w_gsize;
    logic          w_rd_ok;
    logic          w_wn_en, w_ws_en, w_gate;
    logic [IW-1:0] w_wn_addr, w_wn_data, w_ws_addr;
    logic [SW-1:0] w_ws_data;
    logic          w_fit, w_brk, w_last;
    logic [11:0]   w_hraw;

    logic [IW-1:0]     r_clr, n_clr;
    logic [IW-1:0]     r_rover, n_rover;
    logic              r_empty, n_empty;
    logic [NEED_W-1:0] r_need, n_need;
    logic [IW-1:0]     r_prev, n_prev, r_p, n_p;
    logic [SW-1:0]     r_step, n_step;
    logic              r_found, n_found;
    logic [IW-1:0]     r_best, n_best, r_bprev, n_bprev, r_bnext, n_bnext;
    logic [SW-1:0]     r_bsize, n_bsize;
    logic [IW-1:0]     r_blk, n_blk, r_h, n_h, r_q, n_q, r_nh, n_nh;
    logic [SW-1:0]     r_sh, n_sh, r_sp, n_sp;
    logic [1:0]        r_rstat, n_rstat;
    logic [15:0]       r_roff, n_roff;
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_ostatus, n_ostatus;
    logic [15:0]       r_ooff, n_ooff;

    bfa_apb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bfa_hdr_mem #(.DEPTH(ARENA_UNITS), .AW(IW), .SW(SW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (w_rd_addr),
        .o_rd_next (w_mnext),
        .o_rd_size (w_msize),
        .i_wn_en   (w_wn_en && (w_gate || (SW'(w_wn_addr) < w_n))),
        .i_wn_addr (w_wn_addr),
        .i_wn_data (w_wn_data),
        .i_ws_en   (w_ws_en && (w_gate || (SW'(w_ws_addr) < w_n))),
        .i_ws_addr (w_ws_addr),
        .i_ws_data (w_ws_data)
    );

    assign w_n = (CW'(w_cfg.units) < CW'(ARENA_UNITS)) ? SW'(w_cfg.units)
                                                       : SW'(ARENA_UNITS);
    assign w_rd_ok = SW'(r_rd_addr) < w_n;
    assign w_gnext = w_rd_ok ? w_mnext : '0;
    assign w_gsize = w_rd_ok ? w_msize : '0;
    assign w_hraw  = i_in.free_offset[15:4] - 12'd1;

    assign w_fit  = (CW'(w_gsize) >= CW'(r_need)) && (!r_found || (w_gsize < r_bsize));
    assign w_brk  = ((r_h > r_p) && (r_h < w_gnext)) ||
                    ((r_p >= w_gnext) && ((r_h > r_p) || (r_h < w_gnext)));
    assign w_last = (r_step == SW'(ARENA_UNITS));

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ovalid;
    assign o_out.status         = r_ostatus;
    assign o_out.payload_offset = r_ooff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_rover  <= '0;
            r_empty  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_rover  <= n_rover;
            r_empty  <= n_empty;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= w_rd_addr;
        r_need    <= n_need;
        r_prev    <= n_prev;
        r_p       <= n_p;
        r_step    <= n_step;
        r_found   <= n_found;
        r_best    <= n_best;
        r_bprev   <= n_bprev;
        r_bnext   <= n_bnext;
        r_bsize   <= n_bsize;
        r_blk     <= n_blk;
        r_h       <= n_h;
        r_q       <= n_q;
        r_nh      <= n_nh;
        r_sh      <= n_sh;
        r_sp      <= n_sp;
        r_rstat   <= n_rstat;
        r_roff    <= n_roff;
        r_ostatus <= n_ostatus;
        r_ooff    <= n_ooff;
    end

    always_comb begin
        n_state = r_state;   n_clr = r_clr;     n_rover = r_rover; n_empty = r_empty;
        n_need = r_need;     n_prev = r_prev;   n_p = r_p;         n_step = r_step;
        n_found = r_found;   n_best = r_best;   n_bprev = r_bprev; n_bnext = r_bnext;
        n_bsize = r_bsize;   n_blk = r_blk;     n_h = r_h;         n_q = r_q;
        n_nh = r_nh;         n_sh = r_sh;       n_sp = r_sp;
        n_rstat = r_rstat;   n_roff = r_roff;
        n_ovalid = r_ovalid; n_ostatus = r_ostatus; n_ooff = r_ooff;
        w_rd_addr = r_rd_addr;
        w_gate = 1'b0;
        w_wn_en = 1'b0; w_wn_addr = '0; w_wn_data = '0;
        w_ws_en = 1'b0; w_ws_addr = '0; w_ws_data = '0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_gate    = 1'b1;
                w_wn_en   = 1'b1;
                w_wn_addr = r_clr;
                w_ws_en   = 1'b1;
                w_ws_addr = r_clr;
                w_ws_data = ((r_clr == '0) && (w_n != '0)) ? w_n - SW'(1) : '0;
                n_clr     = r_clr + IW'(1);
                if (r_clr == IW'(ARENA_UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_rstat = ST_OK;
                    n_roff  = '0;
                    if (w_n == '0) begin
                        n_rstat = ST_OFF;
                        n_state = S_DONE;
                    end else if (i_in.action == ACT_ALLOC) begin
                        n_need = NEED_W'((17'(i_in.req_bytes) + 17'd15) >> 4) + NEED_W'(1);
                        if (r_empty) begin
                            n_rstat = ST_NOFIT;
                            n_state = S_DONE;
                        end else begin
                            w_rd_addr = r_rover;
                            n_prev    = r_rover;
                            n_found   = 1'b0;
                            n_state   = S_A_START;
                        end
                    end else if ((i_in.free_offset[3:0] != 4'd0) ||
                                 (i_in.free_offset == 16'd0) ||
                                 (CW'(w_hraw) >= CW'(w_n))) begin
                        n_state = S_DONE;
                    end else begin
                        n_h       = IW'(w_hraw);
                        w_rd_addr = IW'(w_hraw);
                        n_state   = S_F_HDR;
                    end
                end
            end
            S_A_START: begin
                n_p       = w_gnext;
                w_rd_addr = w_gnext;
                n_step    = '0;
                n_state   = S_A_WALK;
            end
            S_A_WALK: begin
                if (w_fit) begin
                    n_found = 1'b1;
                    n_best  = r_p;
                    n_bprev = r_prev;
                    n_bsize = w_gsize;
                    n_bnext = w_gnext;
                end
                if ((r_p == r_rover) || w_last) begin
                    n_state = S_A_DECIDE;
                end else begin
                    n_prev    = r_p;
                    n_p       = w_gnext;
                    w_rd_addr = w_gnext;
                    n_step    = r_step + SW'(1);
                end
            end
            S_A_DECIDE: begin
                if (!r_found) begin
                    n_rstat = ST_NOFIT;
                    n_state = S_DONE;
                end else if (CW'(r_bsize) == CW'(r_need)) begin
                    if (r_bnext == r_best) begin
                        n_empty = 1'b1;
                    end else begin
                        w_wn_en   = 1'b1;
                        w_wn_addr = r_bprev;
                        w_wn_data = r_bnext;
                    end
                    n_rover = r_bprev;
                    n_roff  = 16'((32'(r_best) + 32'd1) << 4);
                    n_state = S_DONE;
                end else begin
                    w_ws_en   = 1'b1;
                    w_ws_addr = r_best;
                    w_ws_data = r_bsize - SW'(r_need);
                    n_blk     = r_best + IW'(r_bsize - SW'(r_need));
                    n_rover   = r_bprev;
                    n_state   = S_A_TAIL;
                end
            end
            S_A_TAIL: begin
                w_ws_en   = 1'b1;
                w_ws_addr = r_blk;
                w_ws_data = SW'(r_need);
                n_roff    = 16'((32'(r_blk) + 32'd1) << 4);
                n_state   = S_DONE;
            end
            S_F_HDR: begin
                n_sh = w_msize;
                if ((w_msize == '0) || (CW'(w_msize) > (CW'(w_n) - CW'(r_h)))) begin
                    n_state = S_DONE;
                end else if (r_empty) begin
                    w_wn_en   = 1'b1;
                    w_wn_addr = r_h;
                    w_wn_data = r_h;
                    n_rover   = r_h;
                    n_empty   = 1'b0;
                    n_state   = S_DONE;
                end else begin
                    n_p       = r_rover;
                    w_rd_addr = r_rover;
                    n_step    = '0;
                    n_state   = S_F_WALK;
                end
            end
            S_F_WALK: begin
                if (r_p == r_h) begin
                    n_state = S_DONE;
                end else if (w_brk) begin
                    w_rd_addr = r_p;
                    n_state   = S_F_PQ;
                end else if (w_last) begin
                    n_p       = w_gnext;
                    w_rd_addr = w_gnext;
                    n_state   = S_F_PQ;
                end else begin
                    n_p       = w_gnext;
                    w_rd_addr = w_gnext;
                    n_step    = r_step + SW'(1);
                end
            end
            S_F_PQ: begin
                n_sp      = w_gsize;
                n_q       = w_gnext;
                w_rd_addr = w_gnext;
                n_state   = S_F_Q;
            end
            S_F_Q: begin
                n_state = S_F_P;
                if ((SW+1)'(r_h) + (SW+1)'(r_sh) == (SW+1)'(r_q)) begin
                    n_sh      = r_sh + w_gsize;
                    w_ws_en   = 1'b1;
                    w_ws_addr = r_h;
                    w_ws_data = r_sh + w_gsize;
                    w_wn_en   = 1'b1;
                    w_wn_addr = r_h;
                    if (r_q == r_p) begin
                        w_wn_data = r_h;
                        n_rover   = r_h;
                        n_state   = S_DONE;
                    end else begin
                        w_wn_data = w_gnext;
                        n_nh      = w_gnext;
                    end
                end else begin
                    w_wn_en   = 1'b1;
                    w_wn_addr = r_h;
                    w_wn_data = r_q;
                    n_nh      = r_q;
                end
            end
            S_F_P: begin
                w_wn_en   = 1'b1;
                w_wn_addr = r_p;
                if ((SW+1)'(r_p) + (SW+1)'(r_sp) == (SW+1)'(r_h)) begin
                    w_ws_en   = 1'b1;
                    w_ws_addr = r_p;
                    w_ws_data = r_sp + r_sh;
                    w_wn_data = r_nh;
                end else begin
                    w_wn_data = r_h;
                end
                n_rover = r_p;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_rstat;
                    n_ooff    = r_roff;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_cfg.wr) begin
            n_state = S_CLEAR;
            n_clr   = '0;
            n_rover = '0;
            n_empty = 1'b0;
        end
    end

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

    a_tail_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_TAIL) |-> $past(r_state == S_A_DECIDE))
        else $error("tail split without a best-fit decision");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_A_WALK) || (r_state == S_F_WALK)) |-> (r_step <= SW'(ARENA_UNITS)))
        else $error("list walk exceeded its step bound");

endmodule
